// ----- hw/rtl/rbsr_pkg.sv -----
// rbsr_pkg: shared constants and types for the red-black stencil relaxation block
// no dependencies
`default_nettype none
package rbsr_pkg;
  localparam int unsigned MaxRows   = 64;
  localparam int unsigned MaxCols   = 64;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned RowW      = $clog2(MaxRows);
  localparam int unsigned ColW      = $clog2(MaxCols);
  localparam int unsigned AddrW     = RowW + ColW;
  localparam int unsigned Depth     = MaxRows * MaxCols;
  localparam int unsigned SumW      = DataWidth + 3;

  typedef enum logic [1:0] {
    KindWrite = 2'd0,
    KindRun   = 2'd1,
    KindRead  = 2'd2,
    KindNone  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CfgRows  = 2'd0,
    CfgCols  = 2'd1,
    CfgSweep = 2'd2,
    CfgNone  = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    StIdle,
    StRead,
    StRdOut,
    StSweep,
    StCell,
    StFetch,
    StAcc,
    StDiv,
    StWrite,
    StDone
  } state_e;
endpackage
`default_nettype wire

// ----- hw/rtl/red_black_stencil_relax.sv -----
// red_black_stencil_relax: grid store with red-black five-point relaxation
// depends on rbsr_pkg and rbsr_ram
//
// channel | signals                           | direction
// item    | start_i kind_i row_i col_i value_i, busy_o | in, busy_o out
// result  | done_o read_data_o addr_error_o   | out
// config  | cfg_we_i cfg_idx_i cfg_data_i     | in
//
// a read item outside the grid skips the ram read
// run item: each pass relaxes the inner cells of one colour; each cell takes
// 5 ram reads over one port and a shift-add divide by 5 with a short correction loop;
// the sums, shift-adds and remainder subtractions share one adder
// reset leaves the grid undefined, no clearing pass; results cannot be stalled
`default_nettype none
module red_black_stencil_relax (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  output logic                                   busy_o,
  input  wire logic [1:0]                        kind_i,
  input  wire logic [rbsr_pkg::RowW-1:0]         row_i,
  input  wire logic [rbsr_pkg::ColW-1:0]         col_i,
  input  wire logic signed [31:0]                value_i,
  input  wire logic                              cfg_we_i,
  input  wire logic [1:0]                        cfg_idx_i,
  input  wire logic [15:0]                       cfg_data_i,
  output logic                                   done_o,
  output logic signed [31:0]                     read_data_o,
  output logic                                   addr_error_o
);
  import rbsr_pkg::*;

  state_e state_q, state_d;
  logic [6:0]  rows_q, cols_q;
  logic [15:0] sweeps_q;
  logic [15:0] pass_q, pass_d;
  logic [RowW-1:0] r_q, r_d;
  logic [ColW-1:0] c_q, c_d;
  logic [2:0]  nb_q, nb_d;
  logic [5:0]  bit_q, bit_d;
  logic signed [SumW-1:0] sum_q, sum_d;
  logic [SumW-1:0] quo_q, quo_d, rem_q, rem_d;
  logic        neg_q, neg_d;
  logic        done_q, done_d, err_q, err_d;
  logic [31:0] rd_q, rd_d;
  logic        we;
  logic [AddrW-1:0] addr;
  logic [DataWidth-1:0] wdata, rdata;
  logic [6:0]  nr, nc;
  logic        bad;
  logic [AddrW-1:0] here;
  logic [SumW-1:0] mag;
  logic [SumW-1:0] add_a, add_b, add_y;
  logic        add_sub;
  logic [ColW:0] c_next;
  logic [RowW:0] r_next;
  logic        par;

  assign nr = (rows_q > 7'(MaxRows)) ? 7'(MaxRows) : rows_q;
  assign nc = (cols_q > 7'(MaxCols)) ? 7'(MaxCols) : cols_q;
  assign bad = ({1'b0, row_i} >= nr) || ({1'b0, col_i} >= nc);
  assign here = {r_q, c_q};
  assign par = ~pass_q[0];
  assign mag = sum_q[SumW-1] ? SumW'(-sum_q) : SumW'(sum_q);
  assign add_y = add_sub ? (add_a - add_b) : (add_a + add_b);

  rbsr_ram #(.Width(DataWidth), .Depth(Depth)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .addr_i (addr),
    .wdata_i(wdata),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      rows_q   <= 7'd64;
      cols_q   <= 7'd64;
      sweeps_q <= 16'd2;
      done_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CfgRows:  rows_q   <= cfg_data_i[6:0];
          CfgCols:  cols_q   <= cfg_data_i[6:0];
          CfgSweep: sweeps_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pass_q <= pass_d;
    r_q    <= r_d;
    c_q    <= c_d;
    nb_q   <= nb_d;
    bit_q  <= bit_d;
    sum_q  <= sum_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    neg_q  <= neg_d;
    err_q  <= err_d;
    rd_q   <= rd_d;
  end

  always_comb begin
    state_d = state_q;
    pass_d = pass_q; r_d = r_q; c_d = c_q; nb_d = nb_q; bit_d = bit_q;
    sum_d = sum_q; quo_d = quo_q; rem_d = rem_q; neg_d = neg_q;
    err_d = err_q; rd_d = rd_q; done_d = 1'b0;
    we = 1'b0; addr = here; wdata = quo_q[DataWidth-1:0];
    c_next = '0; r_next = '0;
    add_a = '0; add_b = '0; add_sub = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          err_d = 1'b0; rd_d = '0;
          r_d = row_i; c_d = col_i;
          unique case (kind_e'(kind_i))
            KindWrite: begin
              err_d = bad;
              addr = {row_i, col_i};
              wdata = value_i[DataWidth-1:0];
              we = !bad;
              state_d = StDone;
            end
            KindRead: begin
              err_d = bad;
              addr = {row_i, col_i};
              state_d = bad ? StDone : StRead;
            end
            KindRun: begin
              pass_d = '0;
              state_d = StSweep;
            end
            default: state_d = StDone;
          endcase
        end
      end
      StRead: state_d = StRdOut;
      StRdOut: begin
        rd_d = 32'(signed'(rdata));
        state_d = StDone;
      end
      StSweep: begin
        if (pass_q == sweeps_q || nr < 7'd3 || nc < 7'd3) begin
          state_d = StDone;
        end else begin
          r_d = RowW'(1);
          c_d = par ? ColW'(2) : ColW'(1);
          state_d = StCell;
        end
      end
      StCell: begin
        if ({1'b0, c_q} + 1'b1 >= nc) begin
          r_next = {1'b0, r_q} + 1'b1;
          if (r_next + 1'b1 >= nr) begin
            pass_d = pass_q + 16'd1;
            state_d = StSweep;
          end else begin
            r_d = r_next[RowW-1:0];
            c_d = (r_next[0] ^ par) ? ColW'(1) : ColW'(2);
          end
        end else begin
          nb_d = '0; sum_d = '0;
          addr = here - AddrW'(MaxCols);
          state_d = StFetch;
        end
      end
      StFetch: begin
        add_a = sum_q;
        add_b = SumW'(signed'(rdata));
        sum_d = signed'(add_y);
        nb_d = 3'd1;
        addr = here + AddrW'(MaxCols);
        state_d = StAcc;
      end
      StAcc: begin
        add_a = sum_q;
        add_b = SumW'(signed'(rdata));
        sum_d = signed'(add_y);
        nb_d = nb_q + 3'd1;
        unique case (nb_q)
          3'd1: addr = here - AddrW'(1);
          3'd2: addr = here + AddrW'(1);
          3'd3: addr = here;
          default: ;
        endcase
        if (nb_q == 3'd4) begin
          state_d = StDiv;
          bit_d = '0;
        end
      end
      StDiv: begin
        bit_d = bit_q + 6'd1;
        unique case (bit_q)
          6'd0: begin
            neg_d = sum_q[SumW-1];
            rem_d = mag;
            add_a = mag >> 1;
            add_b = mag >> 2;
            quo_d = add_y;
          end
          6'd1: begin
            add_a = quo_q; add_b = quo_q >> 4; quo_d = add_y;
          end
          6'd2: begin
            add_a = quo_q; add_b = quo_q >> 8; quo_d = add_y;
          end
          6'd3: begin
            add_a = quo_q; add_b = quo_q >> 16; quo_d = add_y;
          end
          6'd4: begin
            add_a = quo_q; add_b = quo_q >> 32; quo_d = add_y;
          end
          6'd5: begin
            add_a = rem_q; add_b = {quo_q[SumW-1:2], 2'b00}; add_sub = 1'b1;
            rem_d = add_y;
            quo_d = quo_q >> 2;
          end
          6'd6: begin
            add_a = rem_q; add_b = quo_q; add_sub = 1'b1;
            rem_d = add_y;
          end
          default: begin
            bit_d = bit_q;
            if (rem_q >= SumW'(5)) begin
              add_a = rem_q; add_b = SumW'(5); add_sub = 1'b1;
              rem_d = add_y;
              quo_d = quo_q + SumW'(1);
            end else begin
              quo_d = neg_q ? -quo_q : quo_q;
              state_d = StWrite;
            end
          end
        endcase
      end
      StWrite: begin
        we = 1'b1;
        c_next = {1'b0, c_q} + 2'd2;
        c_d = c_next[ColW-1:0];
        if (c_next >= nc) c_d = ColW'(MaxCols - 1);
        state_d = StCell;
      end
      StDone: begin
        done_d = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  assign busy_o = (state_q != StIdle);
  assign done_o = done_q;
  assign read_data_o = rd_q;
  assign addr_error_o = err_q;

  ap_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == StIdle) else $error("result outside idle");
  ap_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o) else $error("item not taken");
  ap_err_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && addr_error_o |-> read_data_o == '0) else $error("data on error");
endmodule
`default_nettype wire

// ----- hw/rtl/rbsr_ram.sv -----
// rbsr_ram: generic single-port ram with registered read
// no dependencies
`default_nettype none
module rbsr_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire
